FILE: rtl/bpt_pkg.sv
`timescale 1ns / 1ps

package bpt_pkg;

   // Defaults for the top-level parameters
   localparam int unsigned COEFF_COUNT_DEF         = 10;
   localparam int unsigned LOW_RANDOM_BITS_DEF     = 19;
   localparam int unsigned SCALE_FRACTION_BITS_DEF = 40;

   // Fixed field widths
   localparam int unsigned SAMPLE_W  = 32;
   localparam int unsigned MANT_BITS = 52;
   localparam int unsigned RHIGH_W   = MANT_BITS + 1;
   // Horner accumulator: Q1.52 plus one guard bit for the saturation check
   localparam int unsigned ACC_W     = MANT_BITS + 2;
   localparam int unsigned TABLE_LEN = 14;

   typedef struct packed {
      logic                 frac_zero;  // p is an integer: always accept
      logic                 low_ok;     // ceiling in range and low bits below bound
      logic [RHIGH_W-1:0]   rhigh;
   } bpt_side_type;

   // Horner coefficients of 2^z in Q1.52, highest degree first
   function automatic logic [ACC_W-1:0] poly_coeff(input int unsigned idx);
      logic [ACC_W-1:0] c;
      unique case (idx)
         4:       c = 54'd645325311;
         5:       c = 54'd5541203930;
         6:       c = 54'd69174903955;
         7:       c = 54'd693376144660;
         8:       c = 54'd6005044597685;
         9:       c = 54'd43316165850654;
         10:      c = 54'd250012565434892;
         11:      c = 54'd1081884006853646;
         12:      c = 54'd3121657384091635;
         13:      c = 54'd4503599627370496;
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

FILE: rtl/bpt_front.sv
`timescale 1ns / 1ps

// Scale product and decode: three stages.
module bpt_front
   import bpt_pkg::*;
#(
   parameter int unsigned LOW_RANDOM_BITS     = LOW_RANDOM_BITS_DEF,
   parameter int unsigned SCALE_FRACTION_BITS = SCALE_FRACTION_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [SAMPLE_W-1:0]            in_sample,
   input  logic [RHIGH_W-1:0]             in_rhigh,
   input  logic [LOW_RANDOM_BITS-1:0]     in_rlow,
   input  logic [SCALE_FRACTION_BITS-1:0] scale,
   output logic                           out_valid,
   output logic [SCALE_FRACTION_BITS-1:0] out_z,
   output bpt_side_type                   out_side
);

   localparam int unsigned F      = SCALE_FRACTION_BITS;
   localparam int unsigned SL     = F / 2;
   localparam int unsigned SH     = F - SL;
   localparam int unsigned PLO_W  = SAMPLE_W + SL;
   localparam int unsigned PHI_W  = SAMPLE_W + SH;
   localparam int unsigned PROD_W = SAMPLE_W + F;
   localparam int unsigned SH_W   = $clog2(LOW_RANDOM_BITS + 1);

   // stage 1: two partial products
   logic [2:0]                 valid_ff;
   logic [PLO_W-1:0]           p_lo_ff, p_lo_in;
   logic [PHI_W-1:0]           p_hi_ff, p_hi_in;
   logic [RHIGH_W-1:0]         rhigh1_ff, rhigh2_ff;
   logic [LOW_RANDOM_BITS-1:0] rlow1_ff, rlow2_ff;
   // stage 2: integer and fraction parts
   logic [PROD_W-1:0]          prod_in;
   logic [F-1:0]               frac_ff;
   logic [SAMPLE_W-1:0]        ipart_ff;
   // stage 3: z and flags
   logic [F-1:0]               z_ff, z_in;
   bpt_side_type               side_ff, side_in;
   logic [SH_W-1:0]            shift_amt;
   logic [LOW_RANDOM_BITS-1:0] rlow_shifted;

   assign p_lo_in = PLO_W'(in_sample) * PLO_W'(scale[SL-1:0]);
   assign p_hi_in = PHI_W'(in_sample) * PHI_W'(scale[F-1:SL]);

   assign prod_in = (PROD_W'(p_hi_ff) << SL) + PROD_W'(p_lo_ff);

   assign shift_amt    = SH_W'(LOW_RANDOM_BITS) - ipart_ff[SH_W-1:0];
   assign rlow_shifted = rlow2_ff >> shift_amt;

   always_comb begin
      z_in              = '0 - frac_ff;
      side_in.frac_zero = (frac_ff == '0);
      side_in.low_ok    = (ipart_ff <= SAMPLE_W'(LOW_RANDOM_BITS)) && (rlow_shifted == '0);
      side_in.rhigh     = rhigh2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      p_lo_ff   <= p_lo_in;
      p_hi_ff   <= p_hi_in;
      rhigh1_ff <= in_rhigh;
      rlow1_ff  <= in_rlow;
      frac_ff   <= prod_in[F-1:0];
      ipart_ff  <= prod_in[PROD_W-1:F];
      rhigh2_ff <= rhigh1_ff;
      rlow2_ff  <= rlow1_ff;
      z_ff      <= z_in;
      side_ff   <= side_in;
   end

   assign out_valid = valid_ff[2];
   assign out_z     = z_ff;
   assign out_side  = side_ff;

endmodule

FILE: rtl/bpt_horner_step.sv
`timescale 1ns / 1ps

// One Horner step: acc = floor(acc * z / 2^F) + coeff, over two stages.
module bpt_horner_step
   import bpt_pkg::*;
#(
   parameter int unsigned SCALE_FRACTION_BITS = SCALE_FRACTION_BITS_DEF,
   parameter int unsigned COEFF_INDEX         = TABLE_LEN - 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [ACC_W-1:0]               in_acc,
   input  logic [SCALE_FRACTION_BITS-1:0] in_z,
   input  bpt_side_type                   in_side,
   output logic                           out_valid,
   output logic [ACC_W-1:0]               out_acc,
   output logic [SCALE_FRACTION_BITS-1:0] out_z,
   output bpt_side_type                   out_side
);

   localparam int unsigned F     = SCALE_FRACTION_BITS;
   localparam int unsigned AL    = ACC_W / 2;
   localparam int unsigned AH    = ACC_W - AL;
   localparam int unsigned ZL    = F / 2;
   localparam int unsigned ZH    = F - ZL;
   localparam int unsigned SUM_W = ACC_W + F;

   logic [1:0]          valid_ff;
   logic [AL+ZL-1:0]    pp_ll_ff, pp_ll_in;
   logic [AL+ZH-1:0]    pp_lh_ff, pp_lh_in;
   logic [AH+ZL-1:0]    pp_hl_ff, pp_hl_in;
   logic [AH+ZH-1:0]    pp_hh_ff, pp_hh_in;
   logic [F-1:0]        z1_ff, z2_ff;
   bpt_side_type        side1_ff, side2_ff;
   logic [SUM_W-1:0]    sum_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;

   // stage A: four partial products
   assign pp_ll_in = (AL+ZL)'(in_acc[AL-1:0])     * (AL+ZL)'(in_z[ZL-1:0]);
   assign pp_lh_in = (AL+ZH)'(in_acc[AL-1:0])     * (AL+ZH)'(in_z[F-1:ZL]);
   assign pp_hl_in = (AH+ZL)'(in_acc[ACC_W-1:AL]) * (AH+ZL)'(in_z[ZL-1:0]);
   assign pp_hh_in = (AH+ZH)'(in_acc[ACC_W-1:AL]) * (AH+ZH)'(in_z[F-1:ZL]);

   // stage B: sum, drop F fraction bits, add coefficient
   assign sum_in = (SUM_W'(pp_hh_ff) << (AL + ZL)) + (SUM_W'(pp_hl_ff) << AL)
                 + (SUM_W'(pp_lh_ff) << ZL) + SUM_W'(pp_ll_ff);
   assign acc_in = sum_in[SUM_W-1:F] + poly_coeff(COEFF_INDEX);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      pp_ll_ff <= pp_ll_in;
      pp_lh_ff <= pp_lh_in;
      pp_hl_ff <= pp_hl_in;
      pp_hh_ff <= pp_hh_in;
      z1_ff    <= in_z;
      side1_ff <= in_side;
      acc_ff   <= acc_in;
      z2_ff    <= z1_ff;
      side2_ff <= side1_ff;
   end

   assign out_valid = valid_ff[1];
   assign out_acc   = acc_ff;
   assign out_z     = z2_ff;
   assign out_side  = side2_ff;

endmodule

FILE: rtl/bpt_fifo.sv
`timescale 1ns / 1ps

// Result queue; the upstream credit count keeps it from overflowing.
module bpt_fifo #(
   parameter int unsigned DEPTH = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  logic push_data,
   input  logic pop,
   output logic head_valid,
   output logic head_data
);

   localparam int unsigned AW = $clog2(DEPTH);

   logic [DEPTH-1:0] data_ff;
   logic [AW:0]      wr_ptr_ff, rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff[AW-1:0]] <= push_data;
      end
   end

   assign head_valid = (wr_ptr_ff != rd_ptr_ff);
   assign head_data  = data_ff[rd_ptr_ff[AW-1:0]];

endmodule

FILE: rtl/bernoulli_power_of_two_trial.sv
`timescale 1ns / 1ps

// Channel   Direction  Ports                         Payload
// req       in         req_tvalid/tready/tdata       sample_value, random_high, random_low
// rsp       out        rsp_tvalid/tready/tdata       accept
// csr       in         csr_valid/ready/data          scale_inverse (always ready)
//
// One trial per clock sustained while the credit counter keeps req_tready high. A
// req transfer reaches rsp_tvalid through three front stages for the 32 x F scale
// product and decode, two stages per Horner step, and the result queue.
// The pipeline never stalls; a credit counter sized to the result queue holds
// off req_tready only when the queue could fill while rsp_tready is low.
// Synchronous active-high reset clears valid bits, pointers, the credit count and scale_inverse.
module bernoulli_power_of_two_trial
   import bpt_pkg::*;
#(
   parameter int unsigned COEFF_COUNT         = COEFF_COUNT_DEF,
   parameter int unsigned LOW_RANDOM_BITS     = LOW_RANDOM_BITS_DEF,
   parameter int unsigned SCALE_FRACTION_BITS = SCALE_FRACTION_BITS_DEF,
   localparam int unsigned REQ_DATA_W =
      ((SAMPLE_W + RHIGH_W + LOW_RANDOM_BITS + 7) / 8) * 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [31:0] sample_value, [84:32] random_high, next LOW_RANDOM_BITS random_low
   input  logic [REQ_DATA_W-1:0]          req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [0] accept, [7:1] zero
   output logic [7:0]                     rsp_tdata,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [SCALE_FRACTION_BITS-1:0] csr_data
);

   localparam int unsigned F          = SCALE_FRACTION_BITS;
   localparam int unsigned PIPE_LAT   = 3 + 2 * (COEFF_COUNT - 1);
   localparam int unsigned FIFO_DEPTH = 2 ** $clog2(PIPE_LAT + 1);
   localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);
   localparam int unsigned FIRST_COEF = TABLE_LEN - COEFF_COUNT;
   localparam int unsigned RLOW_LSB   = SAMPLE_W + RHIGH_W;

   logic [F-1:0]     scale_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             req_xfer, rsp_xfer;

   // per-step pipeline taps; index 0 is the front output
   logic                 step_valid [COEFF_COUNT];
   logic [ACC_W-1:0]     step_acc   [COEFF_COUNT];
   logic [F-1:0]         step_z     [COEFF_COUNT];
   bpt_side_type         step_side  [COEFF_COUNT];

   logic                 exit_valid;
   logic [ACC_W-1:0]     exit_acc;
   bpt_side_type         exit_side;
   logic                 high_below;
   logic                 exit_accept;
   logic                 head_data;

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         scale_ff <= csr_data;
      end
   end

   // ---------------- credits ----------------
   // count_ff = items accepted and not yet delivered (in pipe or queue)
   assign req_tready = (count_ff < CNT_W'(FIFO_DEPTH));
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_tvalid && rsp_tready;

   always_comb begin
      count_in = count_ff;
      if (req_xfer && !rsp_xfer) begin
         count_in = count_ff + 1'b1;
      end else if (rsp_xfer && !req_xfer) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // ---------------- front: product, ceiling, z, low-bit bound ----------------
   bpt_front #(
      .LOW_RANDOM_BITS     (LOW_RANDOM_BITS),
      .SCALE_FRACTION_BITS (F)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_xfer),
      .in_sample (req_tdata[SAMPLE_W-1:0]),
      .in_rhigh  (req_tdata[RLOW_LSB-1:SAMPLE_W]),
      .in_rlow   (req_tdata[RLOW_LSB+LOW_RANDOM_BITS-1:RLOW_LSB]),
      .scale     (scale_ff),
      .out_valid (step_valid[0]),
      .out_z     (step_z[0]),
      .out_side  (step_side[0])
   );

   // the leading Horner step on a zero accumulator yields the first coefficient
   assign step_acc[0] = poly_coeff(FIRST_COEF);

   // ---------------- Horner chain ----------------
   for (genvar j = 1; j < COEFF_COUNT; j++) begin : g_step
      bpt_horner_step #(
         .SCALE_FRACTION_BITS (F),
         .COEFF_INDEX         (FIRST_COEF + j)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (step_valid[j-1]),
         .in_acc    (step_acc[j-1]),
         .in_z      (step_z[j-1]),
         .in_side   (step_side[j-1]),
         .out_valid (step_valid[j]),
         .out_acc   (step_acc[j]),
         .out_z     (step_z[j]),
         .out_side  (step_side[j])
      );
   end

   // ---------------- decision ----------------
   assign exit_valid = step_valid[COEFF_COUNT-1];
   assign exit_acc   = step_acc[COEFF_COUNT-1];
   assign exit_side  = step_side[COEFF_COUNT-1];

   // mantissa saturates at 2^53 - 1 when the guard bit is set
   assign high_below = exit_acc[ACC_W-1] ? (exit_side.rhigh != '1)
                                         : (exit_side.rhigh < exit_acc[RHIGH_W-1:0]);
   assign exit_accept = exit_side.frac_zero || (exit_side.low_ok && high_below);

   bpt_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (exit_valid),
      .push_data  (exit_accept),
      .pop        (rsp_xfer),
      .head_valid (rsp_tvalid),
      .head_data  (head_data)
   );

   assign rsp_tdata = {7'd0, head_data};

   // ---------------- assertions ----------------
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FIFO_DEPTH))
      else $error("credit count above queue depth");

   a_idle_empty : assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (!rsp_tvalid && !exit_valid))
      else $error("result present with no item in flight");

   a_credit_return : assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && !req_xfer) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("credit not returned on response transfer");

endmodule
